>>> rtl/rscq_pkg.sv
`default_nettype none

package rscq_pkg;

  localparam int unsigned ChanW = 8;
  localparam int unsigned CfgIdxW = 2;

  // floor(s / 3) for s <= 765 as (s * 683) >> 11
  localparam int unsigned SumW = ChanW + 2;
  localparam int unsigned ProdW = 20;
  localparam logic [ProdW-1:0] MeanRecip = 20'd683;
  localparam int unsigned MeanShift = 11;

  localparam logic [ChanW-1:0] LevelBright = 8'hFF;
  localparam logic [ChanW-1:0] LevelDark = 8'h80;
  localparam logic [ChanW-1:0] LevelGray = 8'hC0;
  localparam logic [ChanW-1:0] LevelOff = 8'h00;

  localparam logic [ChanW-1:0] ChromaThresholdRst = 8'd127;
  localparam logic [ChanW-1:0] BrightnessSplitRst = 8'd127;
  localparam logic [ChanW-1:0] WhiteLevelRst = 8'd191;
  localparam logic [ChanW-1:0] GrayLevelRst = 8'd127;

  typedef enum logic [CfgIdxW-1:0] {
    CfgChromaThreshold = 2'd0,
    CfgBrightnessSplit = 2'd1,
    CfgWhiteLevel      = 2'd2,
    CfgGrayLevel       = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ClsBlack       = 4'd0,
    ClsRed         = 4'd1,
    ClsGreen       = 4'd2,
    ClsBlue        = 4'd3,
    ClsYellow      = 4'd4,
    ClsMagenta     = 4'd5,
    ClsCyan        = 4'd6,
    ClsWhite       = 4'd7,
    ClsGray        = 4'd8,
    ClsDarkRed     = 4'd9,
    ClsDarkGreen   = 4'd10,
    ClsDarkBlue    = 4'd11,
    ClsDarkYellow  = 4'd12,
    ClsDarkMagenta = 4'd13,
    ClsDarkCyan    = 4'd14,
    ClsDarkGray    = 4'd15
  } color_class_e;

  typedef struct packed {
    logic [ChanW-1:0] chroma_threshold;
    logic [ChanW-1:0] brightness_split;
    logic [ChanW-1:0] white_level;
    logic [ChanW-1:0] gray_level;
  } cfg_t;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } pixel_t;

  typedef struct packed {
    color_class_e     color_class;
    logic [ChanW-1:0] out_red;
    logic [ChanW-1:0] out_green;
    logic [ChanW-1:0] out_blue;
  } result_t;

  // palette color of a class, packed red, green, blue
  function automatic pixel_t palette(color_class_e cls);
    pixel_t p;
    p = '{LevelOff, LevelOff, LevelOff};
    case (cls)
      ClsBlack:       p = '{LevelOff, LevelOff, LevelOff};
      ClsRed:         p = '{LevelBright, LevelOff, LevelOff};
      ClsGreen:       p = '{LevelOff, LevelBright, LevelOff};
      ClsBlue:        p = '{LevelOff, LevelOff, LevelBright};
      ClsYellow:      p = '{LevelBright, LevelBright, LevelOff};
      ClsMagenta:     p = '{LevelBright, LevelOff, LevelBright};
      ClsCyan:        p = '{LevelOff, LevelBright, LevelBright};
      ClsWhite:       p = '{LevelBright, LevelBright, LevelBright};
      ClsGray:        p = '{LevelGray, LevelGray, LevelGray};
      ClsDarkRed:     p = '{LevelDark, LevelOff, LevelOff};
      ClsDarkGreen:   p = '{LevelOff, LevelDark, LevelOff};
      ClsDarkBlue:    p = '{LevelOff, LevelOff, LevelDark};
      ClsDarkYellow:  p = '{LevelDark, LevelDark, LevelOff};
      ClsDarkMagenta: p = '{LevelDark, LevelOff, LevelDark};
      ClsDarkCyan:    p = '{LevelOff, LevelDark, LevelDark};
      ClsDarkGray:    p = '{LevelDark, LevelDark, LevelDark};
      default:        p = '{LevelOff, LevelOff, LevelOff};
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

>>> rtl/rscq_pixel_if.sv
`default_nettype none

interface rscq_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

>>> rtl/rscq_color_if.sv
`default_nettype none

interface rscq_color_if;
  logic       valid;
  logic       ready;
  logic [3:0] color_class;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;

  modport source (
    output valid, output color_class, output out_red, output out_green, output out_blue,
    input ready
  );
  modport sink (
    input valid, input color_class, input out_red, input out_green, input out_blue,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/rgb_to_sixteen_color_quantizer_top.sv
// An accepted pixel word passes the input register, then the result register.
// Throughput: 1 pixel per cycle; the input register and the result register
// each advance whenever the stage behind them is empty or being drained.
// Reset: rst_ni asynchronous, active low; empties both stages and loads the
// threshold registers with 127, 127, 191, 127.
`default_nettype none

module rgb_to_sixteen_color_quantizer_top (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  rscq_pixel_if.sink                        pixel_i,
  rscq_color_if.source                      color_o,
  input  wire logic                         cfg_we_i,
  input  wire logic [rscq_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [rscq_pkg::ChanW-1:0]   cfg_wdata_i
);
  import rscq_pkg::*;

  cfg_t    cfg;
  logic    in_v_q;
  pixel_t  in_pix_q;
  logic    out_v_q;
  result_t out_res_q;
  result_t res_d;
  logic    in_rdy;
  logic    out_rdy;

  rscq_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  rscq_classify u_classify (
    .pix_i (in_pix_q),
    .cfg_i (cfg),
    .res_o (res_d)
  );

  assign out_rdy = !out_v_q || color_o.ready;
  assign in_rdy  = !in_v_q || out_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (in_rdy) begin
        in_v_q <= pixel_i.valid;
      end
      if (out_rdy) begin
        out_v_q <= in_v_q;
      end
    end
  end

  // payload registers: load only on a move
  always_ff @(posedge clk_i) begin
    if (pixel_i.valid && in_rdy) begin
      in_pix_q <= '{pixel_i.red, pixel_i.green, pixel_i.blue};
    end
    if (in_v_q && out_rdy) begin
      out_res_q <= res_d;
    end
  end

  assign pixel_i.ready        = in_rdy;
  assign color_o.valid        = out_v_q;
  assign color_o.color_class  = out_res_q.color_class;
  assign color_o.out_red      = out_res_q.out_red;
  assign color_o.out_green    = out_res_q.out_green;
  assign color_o.out_blue     = out_res_q.out_blue;

  a_no_dark_gray: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> out_res_q.color_class != ClsDarkGray)
    else $error("dark gray class produced");

  a_palette_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> {out_res_q.out_red, out_res_q.out_green, out_res_q.out_blue}
                == palette(out_res_q.color_class))
    else $error("output color does not match its class");

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pixel_i.valid && pixel_i.ready) |=> in_v_q)
    else $error("accepted pixel word not held in input stage");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_v_q && !out_rdy) |=> (in_v_q && $stable(in_pix_q)))
    else $error("input stage lost a pixel word during output stall");

endmodule

`default_nettype wire

>>> rtl/rscq_cfg_regs.sv
`default_nettype none

module rscq_cfg_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [rscq_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [rscq_pkg::ChanW-1:0]    cfg_wdata_i,
  output rscq_pkg::cfg_t                     cfg_o
);
  import rscq_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.chroma_threshold <= ChromaThresholdRst;
      cfg_q.brightness_split <= BrightnessSplitRst;
      cfg_q.white_level      <= WhiteLevelRst;
      cfg_q.gray_level       <= GrayLevelRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgChromaThreshold: cfg_q.chroma_threshold <= cfg_wdata_i;
        CfgBrightnessSplit: cfg_q.brightness_split <= cfg_wdata_i;
        CfgWhiteLevel:      cfg_q.white_level      <= cfg_wdata_i;
        CfgGrayLevel:       cfg_q.gray_level       <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

>>> rtl/rscq_classify.sv
`default_nettype none

module rscq_classify (
  input  wire rscq_pkg::pixel_t pix_i,
  input  wire rscq_pkg::cfg_t   cfg_i,
  output rscq_pkg::result_t     res_o
);
  import rscq_pkg::*;

  logic [ChanW:0]   sum_rg, sum_rb, sum_gb;
  logic [ChanW-1:0] avg_rg, avg_rb, avg_gb;
  logic [SumW-1:0]  sum_all;
  logic [ProdW-1:0] mean_prod;
  logic [ChanW-1:0] mean;
  logic [ChanW-1:0] cand [6];
  logic [ChanW-1:0] comp [6];
  logic [5:0]       dom;
  logic             dark;
  color_class_e     cls;
  pixel_t           pal;

  assign sum_rg = {1'b0, pix_i.red} + {1'b0, pix_i.green};
  assign sum_rb = {1'b0, pix_i.red} + {1'b0, pix_i.blue};
  assign sum_gb = {1'b0, pix_i.green} + {1'b0, pix_i.blue};
  assign avg_rg = sum_rg[ChanW:1];
  assign avg_rb = sum_rb[ChanW:1];
  assign avg_gb = sum_gb[ChanW:1];

  assign sum_all   = SumW'(pix_i.red) + SumW'(pix_i.green) + SumW'(pix_i.blue);
  assign mean_prod = ProdW'(sum_all) * MeanRecip;
  assign mean      = mean_prod[MeanShift +: ChanW];

  // candidates in priority order: red, green, blue, yellow, magenta, cyan
  assign cand[0] = pix_i.red;   assign comp[0] = avg_gb;
  assign cand[1] = pix_i.green; assign comp[1] = avg_rb;
  assign cand[2] = pix_i.blue;  assign comp[2] = avg_rg;
  assign cand[3] = avg_rg;      assign comp[3] = pix_i.blue;
  assign cand[4] = avg_rb;      assign comp[4] = pix_i.green;
  assign cand[5] = avg_gb;      assign comp[5] = pix_i.red;

  // a - b > thr rewritten as a > b + thr to stay unsigned
  always_comb begin
    for (int k = 0; k < 6; k++) begin
      dom[k] = {1'b0, cand[k]} > ({1'b0, comp[k]} + {1'b0, cfg_i.chroma_threshold});
    end
  end

  assign dark = mean <= cfg_i.brightness_split;

  always_comb begin
    if (dom[0]) begin
      cls = dark ? ClsDarkRed : ClsRed;
    end else if (dom[1]) begin
      cls = dark ? ClsDarkGreen : ClsGreen;
    end else if (dom[2]) begin
      cls = dark ? ClsDarkBlue : ClsBlue;
    end else if (dom[3]) begin
      cls = dark ? ClsDarkYellow : ClsYellow;
    end else if (dom[4]) begin
      cls = dark ? ClsDarkMagenta : ClsMagenta;
    end else if (dom[5]) begin
      cls = dark ? ClsDarkCyan : ClsCyan;
    end else if (mean > cfg_i.white_level) begin
      cls = ClsWhite;
    end else if (mean > cfg_i.gray_level) begin
      cls = ClsGray;
    end else begin
      cls = ClsBlack;
    end
  end

  assign pal = palette(cls);

  assign res_o.color_class = cls;
  assign res_o.out_red     = pal.red;
  assign res_o.out_green   = pal.green;
  assign res_o.out_blue    = pal.blue;

endmodule

`default_nettype wire

>>> verif/tb_top.sv
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rscq_pkg::*;

  localparam int unsigned NumPhases = 6;
  localparam int unsigned WordsPerPhase = 250;
  localparam int unsigned NumProbes = 21;
  localparam int unsigned HoldCycles = 80;
  localparam int unsigned HoldAfterWords = 400;

  typedef struct packed {
    pixel_t       px;
    logic         known;
    color_class_e cls;
  } probe_t;

  logic     clk;
  logic     rst_n;
  logic     cfg_we;
  cfg_idx_e cfg_index;
  logic [ChanW-1:0] cfg_wdata;

  rscq_pixel_if pixel_bus ();
  rscq_color_if color_bus ();

  rgb_to_sixteen_color_quantizer_top DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .pixel_i    (pixel_bus),
    .color_o    (color_bus),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_wdata_i(cfg_wdata)
  );

  cfg_t    thresholds;
  result_t expected_colors[$];
  int      errors;
  int      colors_seen;
  int      src_idle_pct;
  int      snk_idle_pct;
  bit      calm;
  bit      hold_active;

  // known rows carry the class that can be read straight off the rules
  probe_t probes[NumProbes] = '{
    '{'{8'd0,   8'd0,   8'd0},   1'b1, ClsBlack},
    '{'{8'd255, 8'd255, 8'd255}, 1'b1, ClsWhite},
    '{'{8'd255, 8'd0,   8'd0},   1'b1, ClsDarkRed},
    '{'{8'd0,   8'd255, 8'd0},   1'b1, ClsDarkGreen},
    '{'{8'd0,   8'd0,   8'd255}, 1'b1, ClsDarkBlue},
    '{'{8'd127, 8'd127, 8'd127}, 1'b1, ClsBlack},
    '{'{8'd128, 8'd128, 8'd128}, 1'b1, ClsGray},
    '{'{8'd191, 8'd191, 8'd191}, 1'b1, ClsGray},
    '{'{8'd192, 8'd192, 8'd192}, 1'b1, ClsWhite},
    '{'{8'd180, 8'd180, 8'd180}, 1'b1, ClsGray},
    '{'{8'd255, 8'd200, 8'd0},   1'b0, ClsBlack},
    '{'{8'd200, 8'd255, 8'd0},   1'b0, ClsBlack},
    '{'{8'd0,   8'd200, 8'd255}, 1'b0, ClsBlack},
    '{'{8'd254, 8'd254, 8'd0},   1'b0, ClsBlack},
    '{'{8'd190, 8'd190, 8'd0},   1'b0, ClsBlack},
    '{'{8'd254, 8'd0,   8'd254}, 1'b0, ClsBlack},
    '{'{8'd190, 8'd0,   8'd190}, 1'b0, ClsBlack},
    '{'{8'd0,   8'd254, 8'd254}, 1'b0, ClsBlack},
    '{'{8'd0,   8'd190, 8'd190}, 1'b0, ClsBlack},
    '{'{8'd255, 8'd255, 8'd0},   1'b0, ClsBlack},
    '{'{8'd0,   8'd255, 8'd255}, 1'b0, ClsBlack}
  };

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic result_t paint(input color_class_e cls);
    result_t    res;
    logic [2:0] lit;
    logic [ChanW-1:0] level;
    level = LevelBright;
    case (cls)
      ClsRed:         lit = 3'b100;
      ClsGreen:       lit = 3'b010;
      ClsBlue:        lit = 3'b001;
      ClsYellow:      lit = 3'b110;
      ClsMagenta:     lit = 3'b101;
      ClsCyan:        lit = 3'b011;
      ClsWhite:       lit = 3'b111;
      ClsGray:        begin lit = 3'b111; level = LevelGray; end
      ClsDarkRed:     begin lit = 3'b100; level = LevelDark; end
      ClsDarkGreen:   begin lit = 3'b010; level = LevelDark; end
      ClsDarkBlue:    begin lit = 3'b001; level = LevelDark; end
      ClsDarkYellow:  begin lit = 3'b110; level = LevelDark; end
      ClsDarkMagenta: begin lit = 3'b101; level = LevelDark; end
      ClsDarkCyan:    begin lit = 3'b011; level = LevelDark; end
      ClsDarkGray:    begin lit = 3'b111; level = LevelDark; end
      default:        lit = 3'b000;
    endcase
    res.color_class = cls;
    res.out_red = lit[2] ? level : LevelOff;
    res.out_green = lit[1] ? level : LevelOff;
    res.out_blue = lit[0] ? level : LevelOff;
    return res;
  endfunction

  function automatic result_t quantize(input pixel_t px);
    int r, g, b, rg, rb, gb, mean, winner;
    int margin[6];
    color_class_e cls;
    r = int'(px.red);
    g = int'(px.green);
    b = int'(px.blue);
    rg = (r + g) / 2;
    rb = (r + b) / 2;
    gb = (g + b) / 2;
    mean = (r + g + b) / 3;
    // priority: red, green, blue, yellow, magenta, cyan
    margin[0] = r - gb;
    margin[1] = g - rb;
    margin[2] = b - rg;
    margin[3] = rg - b;
    margin[4] = rb - g;
    margin[5] = gb - r;
    winner = -1;
    for (int k = 0; k < 6; k++) begin
      if (winner < 0 && margin[k] > int'(thresholds.chroma_threshold)) winner = k;
    end
    if (winner >= 0) begin
      if (mean <= int'(thresholds.brightness_split)) begin
        cls = color_class_e'(int'(ClsDarkRed) + winner);
      end else begin
        cls = color_class_e'(int'(ClsRed) + winner);
      end
    end else if (mean > int'(thresholds.white_level)) begin
      cls = ClsWhite;
    end else if (mean > int'(thresholds.gray_level)) begin
      cls = ClsGray;
    end else begin
      cls = ClsBlack;
    end
    return paint(cls);
  endfunction

  function automatic logic [ChanW-1:0] clamp_level(input int v);
    if (v < 0) return '0;
    if (v > 255) return 8'd255;
    return v[ChanW-1:0];
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t px;
    int base;
    logic [ChanW-1:0] edges[6] = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd254, 8'd255};
    case ($urandom_range(0, 3))
      0: px = pixel_t'($urandom);
      1: begin
        // near gray: probe the white, gray and black levels
        base = $urandom_range(0, 255);
        px.red = clamp_level(base + $urandom_range(0, 40) - 20);
        px.green = clamp_level(base + $urandom_range(0, 40) - 20);
        px.blue = clamp_level(base + $urandom_range(0, 40) - 20);
      end
      2: begin
        px.red = $urandom_range(0, 1) ? 8'($urandom_range(160, 255)) : 8'($urandom_range(0, 95));
        px.green = $urandom_range(0, 1) ? 8'($urandom_range(160, 255)) : 8'($urandom_range(0, 95));
        px.blue = $urandom_range(0, 1) ? 8'($urandom_range(160, 255)) : 8'($urandom_range(0, 95));
      end
      default: begin
        px.red = $urandom_range(0, 2) == 0 ? 8'($urandom) : edges[$urandom_range(0, 5)];
        px.green = $urandom_range(0, 2) == 0 ? 8'($urandom) : edges[$urandom_range(0, 5)];
        px.blue = $urandom_range(0, 2) == 0 ? 8'($urandom) : edges[$urandom_range(0, 5)];
      end
    endcase
    return px;
  endfunction

  function automatic cfg_t phase_settings(input int ph);
    cfg_t c;
    case (ph)
      0: c = '{8'd0, 8'd0, 8'd0, 8'd0};
      1: c = '{8'd255, 8'd255, 8'd255, 8'd255};
      2: c = '{8'd30, 8'd100, 8'd40, 8'd220};  // gray level above white level
      3: c = '{8'($urandom_range(0, 80)), 8'($urandom), 8'($urandom_range(150, 255)),
               8'($urandom_range(60, 150))};
      4: c = cfg_t'($urandom);
      default: c = '{ChromaThresholdRst, BrightnessSplitRst, WhiteLevelRst, GrayLevelRst};
    endcase
    return c;
  endfunction

  task automatic flag_mismatch(input string field, input int got, input int want);
    $display("%0t ns: %s mismatch, got %0d expected %0d", $time, field, got, want);
    errors++;
  endtask

  task automatic check_color();
    result_t want;
    colors_seen++;
    if (expected_colors.size() == 0) begin
      flag_mismatch("unexpected word class", int'(color_bus.color_class), -1);
      return;
    end
    want = expected_colors.pop_front();
    if (color_bus.color_class !== want.color_class) begin
      flag_mismatch("color_class", int'(color_bus.color_class), int'(want.color_class));
    end
    if (color_bus.out_red !== want.out_red) begin
      flag_mismatch("out_red", int'(color_bus.out_red), int'(want.out_red));
    end
    if (color_bus.out_green !== want.out_green) begin
      flag_mismatch("out_green", int'(color_bus.out_green), int'(want.out_green));
    end
    if (color_bus.out_blue !== want.out_blue) begin
      flag_mismatch("out_blue", int'(color_bus.out_blue), int'(want.out_blue));
    end
  endtask

  task automatic send_pixel(input pixel_t px, input result_t want);
    if (!calm && !hold_active && $urandom_range(0, 99) < src_idle_pct) begin
      pixel_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    pixel_bus.valid <= 1'b1;
    pixel_bus.red <= px.red;
    pixel_bus.green <= px.green;
    pixel_bus.blue <= px.blue;
    @(posedge clk);
    while (!pixel_bus.ready) @(posedge clk);
    expected_colors.push_back(want);
  endtask

  // drop valid and hold until every expected word is back
  task automatic wait_drained();
    pixel_bus.valid <= 1'b0;
    @(posedge clk);
    while (expected_colors.size() != 0) @(posedge clk);
  endtask

  task automatic load_thresholds(input cfg_t c);
    wait_drained();
    repeat (3) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CfgChromaThreshold;
    cfg_wdata <= c.chroma_threshold;
    @(posedge clk);
    cfg_index <= CfgBrightnessSplit;
    cfg_wdata <= c.brightness_split;
    @(posedge clk);
    cfg_index <= CfgWhiteLevel;
    cfg_wdata <= c.white_level;
    @(posedge clk);
    cfg_index <= CfgGrayLevel;
    cfg_wdata <= c.gray_level;
    @(posedge clk);
    cfg_we <= 1'b0;
    thresholds = c;
  endtask

  // output side: check every accepted word, then pick ready for the next cycle
  initial begin
    int gap_left;
    bit held;
    gap_left = 0;
    held = 1'b0;
    color_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (color_bus.valid && color_bus.ready) check_color();
      if (!held && colors_seen >= HoldAfterWords) begin
        held = 1'b1;
        hold_active = 1'b1;
        color_bus.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_active = 1'b0;
        color_bus.ready <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
        color_bus.ready <= 1'b0;
      end else if (!calm && rst_n && $urandom_range(0, 99) < snk_idle_pct) begin
        gap_left = $urandom_range(1, 13) - 1;
        color_bus.ready <= 1'b0;
      end else begin
        color_bus.ready <= rst_n;
      end
    end
  end

  initial begin
    pixel_t px;
    int sent;
    errors = 0;
    colors_seen = 0;
    src_idle_pct = 20;
    snk_idle_pct = 20;
    calm = 1'b0;
    hold_active = 1'b0;
    thresholds = '{ChromaThresholdRst, BrightnessSplitRst, WhiteLevelRst, GrayLevelRst};
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CfgChromaThreshold;
    cfg_wdata <= '0;
    pixel_bus.valid <= 1'b0;
    pixel_bus.red <= '0;
    pixel_bus.green <= '0;
    pixel_bus.blue <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (probes[i]) begin
      send_pixel(probes[i].px, probes[i].known ? paint(probes[i].cls) : quantize(probes[i].px));
    end

    sent = 0;
    for (int ph = 0; ph < NumPhases; ph++) begin
      load_thresholds(phase_settings(ph));
      if (ph == NumPhases - 1) begin
        calm = 1'b1;
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      for (int n = 0; n < WordsPerPhase; n++) begin
        if (!calm && sent % 64 == 0) begin
          src_idle_pct = 20 * $urandom_range(0, 2);
          snk_idle_pct = 20 * $urandom_range(0, 2);
        end
        // pause the source mid-phase until the output side catches up
        if (ph == 2 && n == WordsPerPhase / 2) wait_drained();
        px = random_pixel();
        send_pixel(px, quantize(px));
        sent++;
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

`default_nettype wire
